// ===== sv/acc_alu_pkg.sv =====
// Package for the accumulator unit: operation codes, status bits and arithmetic helpers.
package acc_alu_pkg;

   localparam int DATA_W = 8;
   localparam int FUNC_W = 5;

   localparam int FLAG_CY_BIT = 7;
   localparam int FLAG_OV_BIT = 6;
   localparam int FLAG_IE_BIT = 3;
   localparam int FLAG_KEEP_BIT = 4;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_LD   = 5'd0,
      FUNC_AND  = 5'd1,
      FUNC_OR   = 5'd2,
      FUNC_XOR  = 5'd3,
      FUNC_DAD  = 5'd4,
      FUNC_ADD  = 5'd5,
      FUNC_CAD  = 5'd6,
      FUNC_ILD  = 5'd7,
      FUNC_DLD  = 5'd8,
      FUNC_LDE  = 5'd9,
      FUNC_XAE  = 5'd10,
      FUNC_ANE  = 5'd11,
      FUNC_ORE  = 5'd12,
      FUNC_XRE  = 5'd13,
      FUNC_DAE  = 5'd14,
      FUNC_ADE  = 5'd15,
      FUNC_CAE  = 5'd16,
      FUNC_SR   = 5'd17,
      FUNC_SRL  = 5'd18,
      FUNC_RR   = 5'd19,
      FUNC_RRL  = 5'd20,
      FUNC_CCL  = 5'd21,
      FUNC_SCL  = 5'd22,
      FUNC_IEN  = 5'd23,
      FUNC_DINT = 5'd24,
      FUNC_CSA  = 5'd25,
      FUNC_CAS  = 5'd26
   } func_type;

   typedef struct packed {
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] st;
   } alu_res_type;

   // binary add with carry in; sets carry and two's complement overflow
   function automatic alu_res_type bin_add(input logic [DATA_W-1:0] a,
                                           input logic [DATA_W-1:0] b,
                                           input logic [DATA_W-1:0] st);
      logic [DATA_W:0] r;
      alu_res_type     res;
      r = {1'b0, a} + {1'b0, b} + {{DATA_W{1'b0}}, st[FLAG_CY_BIT]};
      res.acc = r[DATA_W-1:0];
      res.st = st;
      res.st[FLAG_CY_BIT] = r[DATA_W];
      res.st[FLAG_OV_BIT] = (a[7] == b[7]) && (a[7] != r[7]);
      return res;
   endfunction

   // BCD add with carry; high digit sum kept in 9 bits, overflow untouched
   function automatic alu_res_type dec_add(input logic [DATA_W-1:0] a,
                                           input logic [DATA_W-1:0] b,
                                           input logic [DATA_W-1:0] st);
      logic [4:0]      lo;
      logic [DATA_W:0] hi;
      logic [DATA_W:0] sum;
      alu_res_type     res;
      lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, st[FLAG_CY_BIT]};
      hi = {1'b0, a[7:4], 4'd0} + {1'b0, b[7:4], 4'd0};
      res.st = st;
      if (lo > 5'h09) begin
         lo = lo - 5'h0A;
         hi = hi + 9'h010;
      end
      if (hi > 9'h090) begin
         hi = hi - 9'h0A0;
         res.st[FLAG_CY_BIT] = 1'b1;
      end else begin
         res.st[FLAG_CY_BIT] = 1'b0;
      end
      sum = hi + {4'd0, lo};
      res.acc = sum[DATA_W-1:0];
      return res;
   endfunction

endpackage

// ===== sv/accumulator_alu_8bit_bcd_top.sv =====
// Accumulator unit top level: input register, one-pass ALU, result register.
//
// Accumulator, extension and status unit of an 8-bit processor. Each item on
// the req_ channel carries an operation code and the memory or immediate byte;
// the unit updates its accumulator, extension register and status byte (bit 7
// carry, bit 6 overflow, bit 3 interrupt enable) and returns all three plus an
// accumulator-is-zero flag on the rsp_ channel, one result per item. The
// accepting edge loads the input register; the item then passes through the
// ALU into the result register, which sets rsp_valid, once that register is
// empty or being drained. Throughput is one item per cycle while rsp_ready
// is high; the ALU reads the state written by the previous item in the same
// cycle that item moves to the result register, so back-to-back dependent
// operations need no bubbles. Both stages keep moving while rsp_ready is high;
// when the result register is held, the input register fills and then
// req_ready drops. Codes 27 to 31 leave the state unchanged and return it.
// ILD and DLD return the write-back byte in rsp_acc_out. Reset clears the
// accumulator, extension and status byte to zero.
module accumulator_alu_8bit_bcd_top
   import acc_alu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [DATA_W-1:0]   req_operand_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DATA_W-1:0]   rsp_acc_out,
   output logic [DATA_W-1:0]   rsp_ext_out,
   output logic [DATA_W-1:0]   rsp_status_out,
   output logic                rsp_acc_zero
);

   // input register
   logic              s1_valid_ff;
   logic [FUNC_W-1:0] s1_func_ff;
   logic [DATA_W-1:0] s1_opnd_ff;

   // architectural state
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] ext_ff, ext_in;
   logic [DATA_W-1:0] st_ff, st_in;

   // result register
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_acc_ff;
   logic [DATA_W-1:0] rsp_ext_ff;
   logic [DATA_W-1:0] rsp_st_ff;
   logic              rsp_zero_ff;

   logic s1_advance;
   logic req_take;

   // s1 moves on when the result register is empty or being drained
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   // ALU: one pass from current state and s1 item to next state
   always_comb begin
      alu_res_type res;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] e;
      a = acc_ff;
      b = s1_opnd_ff;
      e = ext_ff;
      acc_in = acc_ff;
      ext_in = ext_ff;
      st_in  = st_ff;
      res    = '0;
      unique case (s1_func_ff)
         FUNC_LD:   acc_in = b;
         FUNC_AND:  acc_in = a & b;
         FUNC_OR:   acc_in = a | b;
         FUNC_XOR:  acc_in = a ^ b;
         FUNC_DAD: begin
            res = dec_add(a, b, st_ff);
            acc_in = res.acc;
            st_in  = res.st;
         end
         FUNC_ADD: begin
            res = bin_add(a, b, st_ff);
            acc_in = res.acc;
            st_in  = res.st;
         end
         FUNC_CAD: begin
            res = bin_add(a, ~b, st_ff);
            acc_in = res.acc;
            st_in  = res.st;
         end
         FUNC_ILD:  acc_in = b + 8'd1;
         FUNC_DLD:  acc_in = b - 8'd1;
         FUNC_LDE:  acc_in = e;
         FUNC_XAE: begin
            acc_in = e;
            ext_in = a;
         end
         FUNC_ANE:  acc_in = a & e;
         FUNC_ORE:  acc_in = a | e;
         FUNC_XRE:  acc_in = a ^ e;
         FUNC_DAE: begin
            res = dec_add(a, e, st_ff);
            acc_in = res.acc;
            st_in  = res.st;
         end
         FUNC_ADE: begin
            res = bin_add(a, e, st_ff);
            acc_in = res.acc;
            st_in  = res.st;
         end
         FUNC_CAE: begin
            res = bin_add(a, ~e, st_ff);
            acc_in = res.acc;
            st_in  = res.st;
         end
         FUNC_SR:   acc_in = {1'b0, a[DATA_W-1:1]};
         FUNC_SRL:  acc_in = {st_ff[FLAG_CY_BIT], a[DATA_W-1:1]};
         FUNC_RR:   acc_in = {a[0], a[DATA_W-1:1]};
         FUNC_RRL: begin
            // rotate through link: carry in at bit 7, bit 0 out to carry
            acc_in = {st_ff[FLAG_CY_BIT], a[DATA_W-1:1]};
            st_in[FLAG_CY_BIT] = a[0];
         end
         FUNC_CCL:  st_in[FLAG_CY_BIT] = 1'b0;
         FUNC_SCL:  st_in[FLAG_CY_BIT] = 1'b1;
         FUNC_IEN:  st_in[FLAG_IE_BIT] = 1'b1;
         FUNC_DINT: st_in[FLAG_IE_BIT] = 1'b0;
         FUNC_CSA:  acc_in = st_ff;
         FUNC_CAS: begin
            // bit 4 of status is not writable from the accumulator
            st_in = a;
            st_in[FLAG_KEEP_BIT] = st_ff[FLAG_KEEP_BIT];
         end
         default: ; // unused codes: no change
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         ext_ff       <= '0;
         st_ff        <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
            ext_ff       <= ext_in;
            st_ff        <= st_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff <= req_func;
         s1_opnd_ff <= req_operand_byte;
      end
      if (s1_advance) begin
         rsp_acc_ff  <= acc_in;
         rsp_ext_ff  <= ext_in;
         rsp_st_ff   <= st_in;
         rsp_zero_ff <= (acc_in == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_acc_out    = rsp_acc_ff;
   assign rsp_ext_out    = rsp_ext_ff;
   assign rsp_status_out = rsp_st_ff;
   assign rsp_acc_zero   = rsp_zero_ff;

   // a result just produced must match the state it leaves behind
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      $past(s1_advance) |-> (rsp_acc_ff == acc_ff && rsp_ext_ff == ext_ff &&
                             rsp_st_ff == st_ff))
      else $error("result register disagrees with state");

   a_keep_bit4: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_func_ff != FUNC_CAS) |=> st_ff[FLAG_KEEP_BIT] ==
         $past(st_ff[FLAG_KEEP_BIT]))
      else $error("status bit 4 changed outside CAS");

   a_ext_only_xae: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_func_ff != FUNC_XAE) |=> ext_ff == $past(ext_ff))
      else $error("extension changed outside XAE");

   a_zero_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_zero_ff == (rsp_acc_ff == '0)))
      else $error("zero flag disagrees with accumulator");

   a_no_stall_when_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled while pipeline can move");

endmodule

// ===== tb/sv/acc_alu_checker.sv =====
// Checker for the accumulator unit: follows both channels, predicts each result and compares it.
module acc_alu_checker
   import acc_alu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [DATA_W-1:0]   req_operand_byte,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [DATA_W-1:0]   rsp_acc_out,
   input  logic [DATA_W-1:0]   rsp_ext_out,
   input  logic [DATA_W-1:0]   rsp_status_out,
   input  logic                rsp_acc_zero,
   output int                  fail_count,
   output int                  results_due,
   output int                  results_checked
);

   typedef struct packed {
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] ext;
      logic [DATA_W-1:0] st;
   } alu_regs_type;

   alu_regs_type regs_now;
   alu_regs_type due_q[$];

   // binary add of b into the accumulator with carry in
   function automatic alu_regs_type add_binary(input alu_regs_type s,
                                               input logic [DATA_W-1:0] b);
      logic [DATA_W:0] sum;
      alu_regs_type    n;
      n = s;
      sum = {1'b0, s.acc} + {1'b0, b} + {{DATA_W{1'b0}}, s.st[FLAG_CY_BIT]};
      n.acc = sum[DATA_W-1:0];
      n.st[FLAG_CY_BIT] = sum[DATA_W];
      n.st[FLAG_OV_BIT] = (s.acc[7] == b[7]) && (s.acc[7] != sum[7]);
      return n;
   endfunction

   // decimal add: each digit corrected once, high digits summed in 9 bits
   function automatic alu_regs_type add_decimal(input alu_regs_type s,
                                                input logic [DATA_W-1:0] b);
      logic [4:0]      low;
      logic [DATA_W:0] high;
      logic [DATA_W:0] total;
      alu_regs_type    n;
      n = s;
      low = {1'b0, s.acc[3:0]} + {1'b0, b[3:0]} + {4'd0, s.st[FLAG_CY_BIT]};
      high = {1'b0, s.acc[7:4], 4'h0} + {1'b0, b[7:4], 4'h0};
      if (low > 5'd9) begin
         low = low - 5'd10;
         high = high + 9'h010;
      end
      if (high > 9'h090) begin
         high = high - 9'h0A0;
         n.st[FLAG_CY_BIT] = 1'b1;
      end else begin
         n.st[FLAG_CY_BIT] = 1'b0;
      end
      total = high + {4'd0, low};
      n.acc = total[DATA_W-1:0];
      return n;
   endfunction

   function automatic alu_regs_type step_alu(input alu_regs_type s,
                                             input logic [FUNC_W-1:0] f,
                                             input logic [DATA_W-1:0] b);
      alu_regs_type n;
      n = s;
      case (f)
         FUNC_LD:   n.acc = b;
         FUNC_AND:  n.acc = s.acc & b;
         FUNC_OR:   n.acc = s.acc | b;
         FUNC_XOR:  n.acc = s.acc ^ b;
         FUNC_DAD:  n = add_decimal(s, b);
         FUNC_ADD:  n = add_binary(s, b);
         FUNC_CAD:  n = add_binary(s, ~b);
         FUNC_ILD:  n.acc = b + 8'd1;
         FUNC_DLD:  n.acc = b - 8'd1;
         FUNC_LDE:  n.acc = s.ext;
         FUNC_XAE: begin
            n.acc = s.ext;
            n.ext = s.acc;
         end
         FUNC_ANE:  n.acc = s.acc & s.ext;
         FUNC_ORE:  n.acc = s.acc | s.ext;
         FUNC_XRE:  n.acc = s.acc ^ s.ext;
         FUNC_DAE:  n = add_decimal(s, s.ext);
         FUNC_ADE:  n = add_binary(s, s.ext);
         FUNC_CAE:  n = add_binary(s, ~s.ext);
         FUNC_SR:   n.acc = {1'b0, s.acc[7:1]};
         FUNC_SRL:  n.acc = {s.st[FLAG_CY_BIT], s.acc[7:1]};
         FUNC_RR:   n.acc = {s.acc[0], s.acc[7:1]};
         FUNC_RRL: begin
            n.acc = {s.st[FLAG_CY_BIT], s.acc[7:1]};
            n.st[FLAG_CY_BIT] = s.acc[0];
         end
         FUNC_CCL:  n.st[FLAG_CY_BIT] = 1'b0;
         FUNC_SCL:  n.st[FLAG_CY_BIT] = 1'b1;
         FUNC_IEN:  n.st[FLAG_IE_BIT] = 1'b1;
         FUNC_DINT: n.st[FLAG_IE_BIT] = 1'b0;
         FUNC_CSA:  n.acc = s.st;
         FUNC_CAS: begin
            n.st = s.acc;
            n.st[FLAG_KEEP_BIT] = s.st[FLAG_KEEP_BIT];
         end
         default: ;  // spare codes leave everything as it was
      endcase
      return n;
   endfunction

   always @(posedge clock) begin : track
      alu_regs_type want;
      int           errs;
      if (reset) begin
         regs_now <= '0;
         due_q.delete();
         results_due <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: result with no item outstanding: acc %h ext %h status %h zero %b",
                        $time, rsp_acc_out, rsp_ext_out, rsp_status_out, rsp_acc_zero);
               fail_count <= fail_count + 1;
            end else begin
               want = due_q.pop_front();
               errs = 0;
               if (rsp_acc_out !== want.acc) begin
                  $display("%0t: acc_out expected %h got %h", $time, want.acc, rsp_acc_out);
                  errs++;
               end
               if (rsp_ext_out !== want.ext) begin
                  $display("%0t: ext_out expected %h got %h", $time, want.ext, rsp_ext_out);
                  errs++;
               end
               if (rsp_status_out !== want.st) begin
                  $display("%0t: status_out expected %h got %h", $time, want.st, rsp_status_out);
                  errs++;
               end
               if (rsp_acc_zero !== (want.acc == '0)) begin
                  $display("%0t: acc_zero expected %b got %b", $time, want.acc == '0,
                           rsp_acc_zero);
                  errs++;
               end
               fail_count <= fail_count + errs;
               results_checked <= results_checked + 1;
            end
         end
         if (req_valid && req_ready) begin
            want = step_alu(regs_now, req_func, req_operand_byte);
            due_q.push_back(want);
            regs_now <= want;
         end
         results_due <= due_q.size();
      end
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top for the accumulator unit: clock, reset, item stimulus, idling and verdict.
module testbench
   import acc_alu_pkg::*;
();

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_CYCLES     = 60;   // long output hold, longer than the pipe is deep
   localparam int HOLD_ITEMS      = 30;
   localparam int ITEMS_PER_PHASE = 155;
   localparam int SETTLE_CYCLES   = 8;    // idle time before the final report

   // codes past CAS are unused and must leave the state alone
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 5'd27;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 5'd31;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [FUNC_W-1:0]  req_func;
   logic [DATA_W-1:0]  req_operand_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [DATA_W-1:0]  rsp_acc_out;
   logic [DATA_W-1:0]  rsp_ext_out;
   logic [DATA_W-1:0]  rsp_status_out;
   logic               rsp_acc_zero;

   int fail_count;
   int results_due;
   int results_checked;
   int items_sent;
   int cycle_count;
   int send_idle_pct;   // chance per cycle that the sender sits idle
   int rsp_stall_pct;   // chance per cycle that the receiver stalls
   int hold_asks;       // long hold-offs asked of the receiver so far

   accumulator_alu_8bit_bcd_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_operand_byte (req_operand_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_ext_out      (rsp_ext_out),
      .rsp_status_out   (rsp_status_out),
      .rsp_acc_zero     (rsp_acc_zero)
   );

   acc_alu_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_operand_byte (req_operand_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_acc_out      (rsp_acc_out),
      .rsp_ext_out      (rsp_ext_out),
      .rsp_status_out   (rsp_status_out),
      .rsp_acc_zero     (rsp_acc_zero),
      .fail_count       (fail_count),
      .results_due      (results_due),
      .results_checked  (results_checked)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_due);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Receiver: ready redrawn at every falling edge. A new hold request turns
   // into HOLD_CYCLES of ready low, counted here, so the block backs up into req_.
   initial begin : rsp_side
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asks != holds_seen) begin
            holds_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Offers one item. Called at a falling edge, returns at the falling edge
   // after acceptance with valid still high, so back-to-back items never drop
   // valid and raise it again in the same step.
   task automatic send_item(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_operand_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Random item: any of the 32 codes; operands lean toward valid BCD digit
   // pairs so decimal add sees real carries, plus sign and all-ones corners.
   task automatic send_random();
      logic [FUNC_W-1:0] f;
      logic [DATA_W-1:0] b;
      f = FUNC_W'($urandom_range(FUNC_SPARE_LAST));
      case ($urandom_range(7))
         0, 1: b = {4'($urandom_range(9)), 4'($urandom_range(9))};
         2:    b = $urandom_range(1) ? 8'h00 : 8'hFF;
         3:    b = $urandom_range(1) ? 8'h7F : 8'h80;
         default: b = 8'($urandom);
      endcase
      send_item(f, b);
   endtask

   // Sender goes quiet until every outstanding result has come back.
   task automatic wait_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_due != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int phase;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_LD;
      req_operand_byte = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_asks = 0;
      items_sent = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every defined code, the first and last spare codes, and corner cases.
      send_item(FUNC_LD,   8'h00);   // zero flag
      send_item(FUNC_SCL,  8'h00);
      send_item(FUNC_DAD,  8'h99);   // 0 + 99 + carry wraps to 00, carry out
      send_item(FUNC_LD,   8'hFF);
      send_item(FUNC_DAD,  8'hFF);   // non-BCD digits, high sum needs the ninth bit
      send_item(FUNC_CCL,  8'h00);
      send_item(FUNC_LD,   8'h7F);
      send_item(FUNC_ADD,  8'h01);   // positive overflow
      send_item(FUNC_CAD,  8'h00);   // negative overflow with carry out
      send_item(FUNC_AND,  8'h0F);
      send_item(FUNC_OR,   8'hF0);
      send_item(FUNC_XOR,  8'hFF);
      send_item(FUNC_ILD,  8'hFF);   // increment wraps to zero
      send_item(FUNC_DLD,  8'h00);   // decrement wraps to all ones
      send_item(FUNC_XAE,  8'h00);
      send_item(FUNC_LDE,  8'h00);
      send_item(FUNC_ANE,  8'hFF);
      send_item(FUNC_ORE,  8'h00);
      send_item(FUNC_XRE,  8'hFF);
      send_item(FUNC_DAE,  8'h00);
      send_item(FUNC_ADE,  8'hFF);
      send_item(FUNC_CAE,  8'h00);
      send_item(FUNC_SR,   8'h00);
      send_item(FUNC_SRL,  8'hFF);
      send_item(FUNC_RR,   8'h00);
      send_item(FUNC_RRL,  8'hFF);
      send_item(FUNC_IEN,  8'h00);
      send_item(FUNC_LD,   8'hFF);
      send_item(FUNC_CAS,  8'h00);   // status bit 4 must survive the copy
      send_item(FUNC_CSA,  8'h00);
      send_item(FUNC_DINT, 8'hFF);
      send_item(FUNC_SPARE_FIRST, 8'hAA);
      send_item(FUNC_SPARE_LAST,  8'h55);
      wait_results();

      // Output held off for a long stretch while items keep coming.
      hold_asks++;
      repeat (HOLD_ITEMS) send_random();
      wait_results();

      // Random items under four idle/stall mixes, draining after each.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 36; rsp_stall_pct = 36; end
         endcase
         repeat (ITEMS_PER_PHASE) send_random();
         wait_results();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Covered %0d items over all %0d codes, BCD and signed corner operands,",
               items_sent, FUNC_SPARE_LAST + 1);
      $display("four idle/stall mixes and a %0d-cycle output hold; %0d results checked",
               HOLD_CYCLES, results_checked);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
